// ===== rtl/core/vsfp_pkg.sv =====
// ----------------------------------------------------------------------------
// vsfp_pkg - vital sign frame parser shared definitions
// Frame layout, command codes, register map and counter widths.
// ----------------------------------------------------------------------------
package vsfp_pkg;

   // Frame layout
   localparam int unsigned FRAME_BYTES     = 88;
   localparam int unsigned RATE_POSITION   = 65;
   localparam int unsigned OXYGEN_POSITION = 66;
   localparam int unsigned POS_W           = 7;

   localparam logic [7:0] HEADER_BYTE = 8'hFF;

   // Item command codes
   localparam int unsigned CMD_W = 2;
   localparam logic [CMD_W-1:0] CMD_BYTE    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TICK    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

   // Elapsed-time counters
   localparam int unsigned CNT_W = 17;
   localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

   // Register map (word index = paddr[4:2])
   localparam int unsigned ADDR_W = 5;
   localparam int unsigned REG_IDX_W = 3;
   localparam logic [REG_IDX_W-1:0] REG_START_INTERVAL   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_RESTART_TIMEOUT  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_VALID_TIMEOUT    = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_HEART_RATE_LIMIT = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_OXYGEN_LIMIT     = 3'd4;

   localparam logic [15:0] START_INTERVAL_RST   = 16'd200;
   localparam logic [15:0] RESTART_TIMEOUT_RST  = 16'd10000;
   localparam logic [15:0] VALID_TIMEOUT_RST    = 16'd5000;
   localparam logic [7:0]  HEART_RATE_LIMIT_RST = 8'd250;
   localparam logic [7:0]  OXYGEN_LIMIT_RST     = 8'd100;

endpackage

// ===== rtl/core/vsfp_channels.sv =====
// ----------------------------------------------------------------------------
// vsfp channels - request and result handshake channels
// Valid/ready channels carrying one item each.
// ----------------------------------------------------------------------------
interface vsfp_req_if
   import vsfp_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] command;
   logic [7:0]       rx_data;

   modport source (output valid, command, rx_data, input ready);
   modport sink   (input valid, command, rx_data, output ready);
endinterface

interface vsfp_rsp_if;
   logic       valid;
   logic       ready;
   logic       send_start;
   logic       frame_done;
   logic [7:0] heart_rate;
   logic [7:0] oxygen_level;
   logic       reading_valid;
   logic       data_flowing;

   modport source (output valid, send_start, frame_done, heart_rate, oxygen_level,
                   reading_valid, data_flowing, input ready);
   modport sink   (input valid, send_start, frame_done, heart_rate, oxygen_level,
                   reading_valid, data_flowing, output ready);
endinterface

// ===== rtl/core/vital_sign_frame_parser_keepalive.sv =====
// ----------------------------------------------------------------------------
// vital_sign_frame_parser_keepalive - frame parser with start-command keepalive
// Result: registered, and valid in the cycle after the item is accepted.
// Throughput: one item per cycle; input stalls only while a result waits untaken.
// Reset: synchronous; state, counters, registers and result valid back to defaults.
// ----------------------------------------------------------------------------
module vital_sign_frame_parser_keepalive
   import vsfp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   vsfp_req_if.sink          req_chan,
   vsfp_rsp_if.source        rsp_chan,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [15:0] start_interval_ff;
   logic [15:0] restart_timeout_ff;
   logic [15:0] valid_timeout_ff;
   logic [7:0]  rate_limit_ff;
   logic [7:0]  oxygen_limit_ff;

   logic                 csr_write;
   logic [REG_IDX_W-1:0] csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         start_interval_ff  <= START_INTERVAL_RST;
         restart_timeout_ff <= RESTART_TIMEOUT_RST;
         valid_timeout_ff   <= VALID_TIMEOUT_RST;
         rate_limit_ff      <= HEART_RATE_LIMIT_RST;
         oxygen_limit_ff    <= OXYGEN_LIMIT_RST;
      end else if (csr_write) begin
         case (csr_index)
            REG_START_INTERVAL:   start_interval_ff  <= pwdata[15:0];
            REG_RESTART_TIMEOUT:  restart_timeout_ff <= pwdata[15:0];
            REG_VALID_TIMEOUT:    valid_timeout_ff   <= pwdata[15:0];
            REG_HEART_RATE_LIMIT: rate_limit_ff      <= pwdata[7:0];
            REG_OXYGEN_LIMIT:     oxygen_limit_ff    <= pwdata[7:0];
            default: ;            // unmapped words ignore writes
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_START_INTERVAL:   prdata = {16'd0, start_interval_ff};
         REG_RESTART_TIMEOUT:  prdata = {16'd0, restart_timeout_ff};
         REG_VALID_TIMEOUT:    prdata = {16'd0, valid_timeout_ff};
         REG_HEART_RATE_LIMIT: prdata = {24'd0, rate_limit_ff};
         REG_OXYGEN_LIMIT:     prdata = {24'd0, oxygen_limit_ff};
         default:              prdata = 32'd0;
      endcase
   end

   // ------------------------------------------------------------------
   // Parser / keepalive state
   // ------------------------------------------------------------------
   logic [POS_W-1:0] byte_pos_ff,      byte_pos_in;
   logic             in_frame_ff,      in_frame_in;
   logic [7:0]       rate_capture_ff,  rate_capture_in;
   logic [7:0]       oxy_capture_ff,   oxy_capture_in;
   logic [7:0]       rate_held_ff,     rate_held_in;
   logic [7:0]       oxy_held_ff,      oxy_held_in;
   logic             good_ff,          good_in;
   logic             flowing_ff,       flowing_in;
   logic             frame_seen_ff,    frame_seen_in;
   logic [CNT_W-1:0] since_send_ff,    since_send_in;
   logic [CNT_W-1:0] since_frame_ff,   since_frame_in;
   logic [CNT_W-1:0] since_good_ff,    since_good_in;

   // output register
   logic       rsp_valid_ff;
   logic       send_ff,  send_in;
   logic       done_ff,  done_in;

   logic             req_take;
   logic [POS_W-1:0] pos_inc;
   logic [CNT_W-1:0] send_tick, frame_tick, good_tick;

   // Output stage frees itself when the result is taken in the same cycle
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_take       = req_chan.valid && req_chan.ready;

   assign pos_inc    = byte_pos_ff + 1'b1;
   assign send_tick  = (since_send_ff  == COUNT_MAX) ? COUNT_MAX : since_send_ff  + 1'b1;
   assign frame_tick = (since_frame_ff == COUNT_MAX) ? COUNT_MAX : since_frame_ff + 1'b1;
   assign good_tick  = (since_good_ff  == COUNT_MAX) ? COUNT_MAX : since_good_ff  + 1'b1;

   always_comb begin
      byte_pos_in     = byte_pos_ff;
      in_frame_in     = in_frame_ff;
      rate_capture_in = rate_capture_ff;
      oxy_capture_in  = oxy_capture_ff;
      rate_held_in    = rate_held_ff;
      oxy_held_in     = oxy_held_ff;
      good_in         = good_ff;
      flowing_in      = flowing_ff;
      frame_seen_in   = frame_seen_ff;
      since_send_in   = since_send_ff;
      since_frame_in  = since_frame_ff;
      since_good_in   = since_good_ff;
      send_in         = 1'b0;
      done_in         = 1'b0;

      case (req_chan.command)
         CMD_BYTE: begin
            if (req_chan.rx_data == HEADER_BYTE) begin
               // any header byte restarts the frame, even mid-frame
               byte_pos_in = POS_W'(1);
               in_frame_in = 1'b1;
            end else if (in_frame_ff) begin
               if (byte_pos_ff == POS_W'(RATE_POSITION)) begin
                  rate_capture_in = req_chan.rx_data;
               end
               if (byte_pos_ff == POS_W'(OXYGEN_POSITION)) begin
                  oxy_capture_in = req_chan.rx_data;
               end
               byte_pos_in = pos_inc;
               if (pos_inc >= POS_W'(FRAME_BYTES)) begin
                  // last byte: latch reading, check ranges
                  done_in        = 1'b1;
                  since_frame_in = '0;
                  frame_seen_in  = 1'b1;
                  flowing_in     = 1'b1;
                  rate_held_in   = rate_capture_in;
                  oxy_held_in    = oxy_capture_in;
                  if (rate_capture_in != 8'd0 && rate_capture_in <= rate_limit_ff &&
                      oxy_capture_in != 8'd0 && oxy_capture_in <= oxygen_limit_ff) begin
                     since_good_in = '0;
                     good_in       = 1'b1;
                  end
                  in_frame_in = 1'b0;
                  byte_pos_in = '0;
               end
            end
         end
         CMD_TICK: begin
            since_send_in  = send_tick;
            since_frame_in = frame_tick;
            since_good_in  = good_tick;
            if (good_ff && good_tick > {1'b0, valid_timeout_ff}) begin
               good_in = 1'b0;
            end
            if (!flowing_ff) begin
               if (send_tick >= {1'b0, start_interval_ff}) begin
                  send_in       = 1'b1;
                  since_send_in = '0;
               end
            end else if (frame_seen_ff && frame_tick > {1'b0, restart_timeout_ff}) begin
               // frames stopped: back to start-command phase
               flowing_in = 1'b0;
               good_in    = 1'b0;
            end
         end
         CMD_RESTART: begin
            flowing_in    = 1'b0;
            since_send_in = COUNT_MAX;   // next tick requests at once
         end
         default: ;                      // unused code: state unchanged
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff     <= '0;
         in_frame_ff     <= 1'b0;
         rate_capture_ff <= '0;
         oxy_capture_ff  <= '0;
         rate_held_ff    <= '0;
         oxy_held_ff     <= '0;
         good_ff         <= 1'b0;
         flowing_ff      <= 1'b0;
         frame_seen_ff   <= 1'b0;
         since_send_ff   <= COUNT_MAX;
         since_frame_ff  <= '0;
         since_good_ff   <= '0;
      end else if (req_take) begin
         byte_pos_ff     <= byte_pos_in;
         in_frame_ff     <= in_frame_in;
         rate_capture_ff <= rate_capture_in;
         oxy_capture_ff  <= oxy_capture_in;
         rate_held_ff    <= rate_held_in;
         oxy_held_ff     <= oxy_held_in;
         good_ff         <= good_in;
         flowing_ff      <= flowing_in;
         frame_seen_ff   <= frame_seen_in;
         since_send_ff   <= since_send_in;
         since_frame_ff  <= since_frame_in;
         since_good_ff   <= since_good_in;
      end
   end

   // ------------------------------------------------------------------
   // Result register: held/flags already reflect the item's update
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         send_ff <= send_in;
         done_ff <= done_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.send_start    = send_ff;
   assign rsp_chan.frame_done    = done_ff;
   assign rsp_chan.heart_rate    = rate_held_ff;
   assign rsp_chan.oxygen_level  = oxy_held_ff;
   assign rsp_chan.reading_valid = good_ff;
   assign rsp_chan.data_flowing  = flowing_ff;

`ifndef NO_ASSERTIONS
   // a start request is only raised while frames are not flowing
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.send_start |-> !rsp_chan.data_flowing)
      else $error("start request while flowing");

   // a completed frame always puts the block in flowing state
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.frame_done |-> rsp_chan.data_flowing)
      else $error("frame done without flowing");

   // outside a frame the byte position is parked at zero
   assert property (@(posedge clock) disable iff (reset)
      !in_frame_ff |-> byte_pos_ff == '0)
      else $error("byte position nonzero outside frame");

   // every accepted item produces a result in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid_ff)
      else $error("accepted item produced no result");

   // a request and a frame completion never share one item
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !(rsp_chan.send_start && rsp_chan.frame_done))
      else $error("send and frame done together");
`endif

endmodule
